@@ rtl/core/gaussian_polar_sampler_top_assert.svh @@
// Assertion macros for the gaussian polar sampler checker.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef GAUSSIAN_POLAR_SAMPLER_TOP_ASSERT_SVH
`define GAUSSIAN_POLAR_SAMPLER_TOP_ASSERT_SVH

// same-cycle implication, masked during reset
`define GPS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gps: implication check failed");

// next-cycle implication, masked during reset
`define GPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gps: next-cycle check failed");

// holds at every edge, reset included
`define GPS_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) (cond)) \
		else $error("gps: invariant check failed");

`endif

@@ rtl/core/gps_pkg.sv @@
// Shared types and constants of the gaussian polar sampler.
// No dependencies.
package gps_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int LOG_FRAC   = 30;          // fraction bits of the log2 loop
	localparam int LOG_STEPS  = 30;
	localparam int DIV_W      = 32;          // divisor width after pre-shift
	localparam int DIV_STEPS  = DIV_W + 1;   // integer bit plus 32 fraction bits
	localparam int SQRT_STEPS = 32;
	localparam int Q_FRAC     = 56;          // fraction bits of sample^2
	localparam int LN2_W      = 27;
	localparam logic [LN2_W-1:0] TWO_LN2_Q26 = 27'd93032640;
	localparam logic [16:0] SAT_NEG = 17'd32768;
	localparam logic [16:0] SAT_POS = 17'd32767;

	typedef struct packed {
		logic full;
		logic empty;
	} gps_qstat_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_NORM,
		B_LOG,
		B_GVAL,
		B_LVAL,
		B_DIV,
		B_MUL,
		B_SQRT,
		B_EMIT
	} gps_bstate_t;

endpackage

@@ rtl/core/gps_queue.sv @@
// Two-entry queue between the front and the back of the sampler.
// Depends on gps_pkg.
module gps_queue #(
	parameter int EW = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [EW-1:0]       din,
	input  logic                pop,
	output logic [EW-1:0]       dout,
	output gps_pkg::gps_qstat_t qstat
);
	import gps_pkg::*;

	logic [EW-1:0] mem_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    count_q;

	assign qstat.full  = (count_q == 2'd2);
	assign qstat.empty = (count_q == 2'd0);
	assign dout        = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

@@ rtl/core/gps_front.sv @@
// Front of the sampler: takes uniform words, squares the coordinates,
// drops rejected pairs and pushes the rest into the queue. Depends on gps_pkg.
module gps_front #(
	parameter int UNIFORM_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     uniform_valid,
	output logic                     uniform_stall,
	input  logic [UNIFORM_BITS-1:0]  uniform_a,
	input  logic [UNIFORM_BITS-1:0]  uniform_b,
	input  gps_pkg::gps_qstat_t      qstat,
	output logic                     push,
	output logic [2*UNIFORM_BITS-3:0] sq1,
	output logic [2*UNIFORM_BITS-3:0] sq2,
	output logic [2*UNIFORM_BITS-3:0] s,
	output logic                     neg1,
	output logic                     neg2
);
	import gps_pkg::*;

	localparam int P    = UNIFORM_BITS - 1;
	localparam int W    = 2 * P;
	localparam int MW   = P + 1;
	localparam int SQW  = 2 * MW;
	localparam int SUMW = SQW + 1;

	logic                    valid_s1;
	logic [UNIFORM_BITS-1:0] v1_s1, v2_s1;
	logic                    valid_s2;
	logic [SQW-1:0]          sq1_s2, sq2_s2;
	logic                    neg1_s2, neg2_s2;

	logic signed [UNIFORM_BITS:0] ve1, ve2;
	logic [MW-1:0]   m1, m2;
	logic [SUMW-1:0] sum;
	logic            ok_pair, s1_go, s2_go;

	// v = u - 2^P in two's complement is u with its top bit flipped
	assign ve1 = $signed({v1_s1[P], v1_s1});
	assign ve2 = $signed({v2_s1[P], v2_s1});
	assign m1  = MW'(ve1[UNIFORM_BITS] ? -ve1 : ve1);
	assign m2  = MW'(ve2[UNIFORM_BITS] ? -ve2 : ve2);

	assign sum     = SUMW'(sq1_s2) + SUMW'(sq2_s2);
	assign ok_pair = (sum != '0) && (sum < (SUMW'(1) << W));

	assign s2_go         = !valid_s2 || !ok_pair || !qstat.full;
	assign s1_go         = !valid_s1 || s2_go;
	assign uniform_stall = !s1_go;

	assign push = valid_s2 && ok_pair && !qstat.full;
	assign sq1  = W'(sq1_s2);
	assign sq2  = W'(sq2_s2);
	assign s    = W'(sum);
	assign neg1 = neg1_s2;
	assign neg2 = neg2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_go) valid_s1 <= uniform_valid;
			if (s2_go) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && uniform_valid) begin
			v1_s1 <= {~uniform_a[P], uniform_a[P-1:0]};
			v2_s1 <= {~uniform_b[P], uniform_b[P-1:0]};
		end
		if (s2_go) begin
			sq1_s2  <= SQW'(m1) * SQW'(m1);
			sq2_s2  <= SQW'(m2) * SQW'(m2);
			neg1_s2 <= ve1[UNIFORM_BITS];
			neg2_s2 <= ve2[UNIFORM_BITS];
		end
	end

endmodule

@@ rtl/core/gps_back.sv @@
// Back of the sampler: log2 loop, radius scale, divider, multiplier and
// square root sequenced over shared units; drives the result register.
// Depends on gps_pkg.
module gps_back #(
	parameter int UNIFORM_BITS     = 16,
	parameter int SAMPLE_FRAC_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gps_pkg::gps_qstat_t               qstat,
	input  logic [2*UNIFORM_BITS-3:0]         q_sq1,
	input  logic [2*UNIFORM_BITS-3:0]         q_sq2,
	input  logic [2*UNIFORM_BITS-3:0]         q_s,
	input  logic                              q_neg1,
	input  logic                              q_neg2,
	output logic                              pop,
	output logic                              sample_valid,
	input  logic                              sample_stall,
	output logic signed [gps_pkg::SAMPLE_W-1:0] sample,
	output logic                              last
);
	import gps_pkg::*;

	localparam int P   = UNIFORM_BITS - 1;
	localparam int W   = 2 * P;
	localparam int NW  = $clog2(W);
	localparam int SW  = (W > DIV_W) ? W : DIV_W;
	localparam int GW  = $clog2(W + 1) + LOG_FRAC;
	localparam int LPW = GW + LN2_W;
	localparam int LW  = LPW - 32;
	localparam int QPW = DIV_STEPS + LW;
	localparam int SHR = Q_FRAC - 2 * SAMPLE_FRAC_BITS;

	gps_bstate_t state_q, state_nx;
	logic        sel_q;
	logic        valid_q;
	logic        emit;

	logic [W-1:0]        sq1_q, sq2_q, s_q, x_q;
	logic                neg1_q, neg2_q;
	logic [NW-1:0]       lz_q, h_q;
	logic [5:0]          cnt_q;
	logic [LOG_FRAC:0]   lx_q;
	logic [LOG_FRAC-1:0] frac_q;
	logic [GW-1:0]       g_q;
	logic [LW-1:0]       l_q;
	logic [DIV_W:0]      rem_q, quo_q;
	logic [DIV_W-1:0]    b_q;
	logic [63:0]         qx_q, r_q, bit_q;

	// normalize step
	logic [NW:0]         amt;
	logic                hi_zero;
	logic [W-1:0]        x_nx;
	logic [NW-1:0]       lz_nx;
	logic [W+LOG_FRAC:0] xe;
	// log2 step
	logic [2*LOG_FRAC+1:0] lsq;
	logic [LOG_FRAC+1:0]   lt;
	// scale
	logic [NW-1:0]  n;
	logic [31:0]    n32;
	logic [GW-1:0]  g_nx;
	logic [LPW-1:0] lprod;
	logic [QPW-1:0] qprod;
	// divider and root
	logic [DIV_W-1:0] a1, a2, b_nx;
	logic             dbit;
	logic [DIV_W:0]   rem_t;
	logic [63:0]      rb;
	// saturation
	logic [16:0]      mag, magc;
	logic             neg;

	assign amt     = (NW+1)'(1) << cnt_q;
	assign hi_zero = (x_q >> ((NW+1)'(W) - amt)) == '0;
	assign x_nx    = hi_zero ? (x_q << amt) : x_q;
	assign lz_nx   = hi_zero ? (lz_q + NW'(amt)) : lz_q;
	assign xe      = {x_nx, {(LOG_FRAC+1){1'b0}}};

	assign lsq = (2*LOG_FRAC+2)'(lx_q) * (2*LOG_FRAC+2)'(lx_q);
	assign lt  = lsq[2*LOG_FRAC+1:LOG_FRAC];

	assign n     = NW'(W - 1) - lz_q;
	assign n32   = 32'(n);
	// -log2 s = (2P - n) - frac, and 2P - n is lz + 1
	assign g_nx  = ((GW'(lz_q) + GW'(1)) << LOG_FRAC) - GW'(frac_q);
	assign lprod = LPW'(g_q) * LPW'(TWO_LN2_Q26);
	assign qprod = QPW'(quo_q) * QPW'(l_q);

	assign a1   = DIV_W'(SW'(sq1_q) >> h_q);
	assign a2   = DIV_W'(SW'(sq2_q) >> h_q);
	assign b_nx = DIV_W'(SW'(s_q) >> h_q);

	assign dbit  = rem_q >= {1'b0, b_q};
	assign rem_t = dbit ? (rem_q - {1'b0, b_q}) : rem_q;
	assign rb    = r_q + bit_q;

	assign neg  = sel_q ? neg2_q : neg1_q;
	assign mag  = (r_q[31:17] != '0) ? 17'h1FFFF : r_q[16:0];
	assign magc = neg ? ((mag > SAT_NEG) ? SAT_NEG : mag)
	                  : ((mag > SAT_POS) ? SAT_POS : mag);

	assign emit         = (state_q == B_EMIT) && (!valid_q || !sample_stall);
	assign pop          = (state_q == B_IDLE) && !qstat.empty;
	assign sample_valid = valid_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			B_IDLE: if (!qstat.empty) state_nx = B_NORM;
			B_NORM: if (cnt_q == '0) state_nx = B_LOG;
			B_LOG:  if (cnt_q == '0) state_nx = B_GVAL;
			B_GVAL: state_nx = B_LVAL;
			B_LVAL: state_nx = B_DIV;
			B_DIV:  if (cnt_q == '0) state_nx = B_MUL;
			B_MUL:  state_nx = B_SQRT;
			B_SQRT: if (cnt_q == '0) state_nx = B_EMIT;
			B_EMIT: if (emit) state_nx = sel_q ? B_IDLE : B_DIV;
			default: state_nx = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			sel_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (emit) begin
				sel_q   <= ~sel_q;
				valid_q <= 1'b1;
			end else if (!sample_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			sample <= neg ? SAMPLE_W'(17'd0 - magc) : SAMPLE_W'(magc);
			last   <= sel_q;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!qstat.empty) begin
					sq1_q  <= q_sq1;
					sq2_q  <= q_sq2;
					s_q    <= q_s;
					x_q    <= q_s;
					neg1_q <= q_neg1;
					neg2_q <= q_neg2;
					lz_q   <= '0;
					cnt_q  <= 6'(NW - 1);
				end
			end
			B_NORM: begin
				x_q   <= x_nx;
				lz_q  <= lz_nx;
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) begin
					lx_q   <= xe[W+LOG_FRAC -: LOG_FRAC+1];
					frac_q <= '0;
					cnt_q  <= 6'(LOG_STEPS - 1);
				end
			end
			B_LOG: begin
				lx_q   <= lt[LOG_FRAC+1] ? lt[LOG_FRAC+1:1] : lt[LOG_FRAC:0];
				frac_q <= {frac_q[LOG_FRAC-2:0], lt[LOG_FRAC+1]};
				cnt_q  <= cnt_q - 6'd1;
			end
			B_GVAL: begin
				g_q <= g_nx;
				h_q <= (n32 > 32'd31) ? NW'(n32 - 32'd31) : '0;
			end
			B_LVAL: begin
				l_q   <= LW'(lprod >> 32);
				rem_q <= {1'b0, a1};
				b_q   <= b_nx;
				cnt_q <= 6'(DIV_STEPS - 1);
			end
			B_DIV: begin
				rem_q <= rem_t << 1;
				quo_q <= {quo_q[DIV_W-1:0], dbit};
				cnt_q <= cnt_q - 6'd1;
			end
			B_MUL: begin
				qx_q  <= 64'(qprod >> SHR);
				r_q   <= '0;
				bit_q <= 64'(1) << 62;
				cnt_q <= 6'(SQRT_STEPS - 1);
			end
			B_SQRT: begin
				if (qx_q >= rb) begin
					qx_q <= qx_q - rb;
					r_q  <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q - 6'd1;
			end
			B_EMIT: begin
				if (emit && !sel_q) begin
					rem_q <= {1'b0, a2};
					cnt_q <= 6'(DIV_STEPS - 1);
				end
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/core/gaussian_polar_sampler_top.sv @@
// Gaussian sampler by the polar method: front, queue and back.
// Depends on gps_pkg, gps_front, gps_queue and gps_back.
//
// Each input word carries two uniform values; each maps to v in [-1,1).
// Pairs whose s = v1^2 + v2^2 is zero or not below one are dropped in the
// front and produce no output. A kept pair produces two output words,
// v1*m then v2*m with m = sqrt(-2 ln s / s), signed with SAMPLE_FRAC_BITS
// fraction bits and saturated to 16 bits; last marks the second one.
// The front takes a word per cycle until the two-entry queue fills. The
// back handles one pair at a time: a load, the leading-zero search, the
// 30-round log2 squaring loop and the scale states B_GVAL and B_LVAL,
// then per sample a 33-step restoring divider, a multiply, a 32-step
// square root and an emit, all on one shared datapath. Output words sit
// in a result register, so the back moves on to the second sample while
// the first word waits.
module gaussian_polar_sampler_top #(
	parameter int UNIFORM_BITS     = 16,
	parameter int SAMPLE_FRAC_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               uniform_valid,
	output logic                               uniform_stall,
	input  logic [UNIFORM_BITS-1:0]            uniform_a,
	input  logic [UNIFORM_BITS-1:0]            uniform_b,
	output logic                               sample_valid,
	input  logic                               sample_stall,
	output logic signed [gps_pkg::SAMPLE_W-1:0] sample,
	output logic                               last
);
	import gps_pkg::*;

	localparam int W  = 2 * (UNIFORM_BITS - 1);
	localparam int EW = 3 * W + 2;

	gps_qstat_t   qstat;
	logic         push, pop;
	logic [W-1:0] f_sq1, f_sq2, f_s;
	logic         f_neg1, f_neg2;
	logic [W-1:0] q_sq1, q_sq2, q_s;
	logic         q_neg1, q_neg2;

	gps_front #(
		.UNIFORM_BITS(UNIFORM_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.uniform_valid(uniform_valid),
		.uniform_stall(uniform_stall),
		.uniform_a    (uniform_a),
		.uniform_b    (uniform_b),
		.qstat        (qstat),
		.push         (push),
		.sq1          (f_sq1),
		.sq2          (f_sq2),
		.s            (f_s),
		.neg1         (f_neg1),
		.neg2         (f_neg2)
	);

	// queue word: squares, s and the two signs
	gps_queue #(
		.EW(EW)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   ({f_sq1, f_sq2, f_s, f_neg1, f_neg2}),
		.pop   (pop),
		.dout  ({q_sq1, q_sq2, q_s, q_neg1, q_neg2}),
		.qstat (qstat)
	);

	gps_back #(
		.UNIFORM_BITS    (UNIFORM_BITS),
		.SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.qstat       (qstat),
		.q_sq1       (q_sq1),
		.q_sq2       (q_sq2),
		.q_s         (q_s),
		.q_neg1      (q_neg1),
		.q_neg2      (q_neg2),
		.pop         (pop),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample),
		.last        (last)
	);

endmodule

@@ rtl/core/gps_checker.sv @@
// Port-level checks of the gaussian polar sampler, bound to the top level.
// Depends on gps_pkg and gaussian_polar_sampler_top_assert.svh.
`include "gaussian_polar_sampler_top_assert.svh"

module gps_checker #(
	parameter int UNIFORM_BITS = 16
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               uniform_valid,
	input logic                               uniform_stall,
	input logic [UNIFORM_BITS-1:0]            uniform_a,
	input logic [UNIFORM_BITS-1:0]            uniform_b,
	input logic                               sample_valid,
	input logic                               sample_stall,
	input logic signed [gps_pkg::SAMPLE_W-1:0] sample,
	input logic                               last
);
	import gps_pkg::*;

	// a stalled word holds
	`GPS_ASSERT_NEXT(a_out_hold, sample_valid && sample_stall, sample_valid && $stable(sample) && $stable(last))
	// reset empties the result register
	`GPS_ASSERT_ALWAYS(a_rst_empty, arst_n || (sample_valid !== 1'b1))
	// nothing comes out in the cycle right after reset is released
	`GPS_ASSERT_IMPL(a_first_idle, $rose(arst_n), !sample_valid)

endmodule

bind gaussian_polar_sampler_top gps_checker #(
	.UNIFORM_BITS(UNIFORM_BITS)
) u_gps_checker (.*);

@@ sim/testbench.sv @@
// Testbench for the gaussian polar sampler: directed table, then random pairs.
// Depends on gps_pkg and gaussian_polar_sampler_top.
module testbench;
	import gps_pkg::*;

	localparam int UB = 16;
	localparam int FB = 12;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic uniform_valid = 1'b0;
	logic uniform_stall;
	logic [UB-1:0] uniform_a = '0;
	logic [UB-1:0] uniform_b = '0;
	logic sample_valid;
	logic sample_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] sample;
	logic last;

	typedef struct packed {
		logic [15:0] smp;
		logic        lst;
	} sample_word_t;

	// directed row: uniform pair plus an optional typed-in expectation
	typedef struct {
		logic [UB-1:0] a;
		logic [UB-1:0] b;
		bit            has_exp;
		int            n_exp;     // 0 for a rejected pair
		logic [15:0]   s0;
		logic [15:0]   s1;
	} pair_row_t;

	sample_word_t pending_samples[$];
	int errors = 0;
	int n_pairs = 0;
	int n_words = 0;
	int idle_cycles = 0;
	int send_idle_pct = 32;
	int recv_idle_pct = 69;

	always #10 clk = ~clk;

	gaussian_polar_sampler_top u_top (
		.clk(clk), .arst_n(arst_n),
		.uniform_valid(uniform_valid), .uniform_stall(uniform_stall),
		.uniform_a(uniform_a), .uniform_b(uniform_b),
		.sample_valid(sample_valid), .sample_stall(sample_stall),
		.sample(sample), .last(last)
	);

	// ---- predictor ----
	function automatic logic [63:0] isqrt(logic [63:0] x);
		logic [63:0] r, bt;
		r = 0;
		bt = 64'd1 << 62;
		while (bt > x) bt >>= 2;
		while (bt != 0) begin
			if (x >= r + bt) begin
				x -= r + bt;
				r = (r >> 1) + bt;
			end else begin
				r >>= 1;
			end
			bt >>= 2;
		end
		return r;
	endfunction

	// Q1.30 mantissa in [1,2) -> log2 fraction Q0.30 by repeated squaring
	function automatic logic [63:0] log2_mant(logic [63:0] x);
		logic [63:0] res;
		res = 0;
		for (int i = 0; i < 30; i++) begin
			x = (x * x) >> 30;
			if (x >= (64'd1 << 31)) begin
				x >>= 1;
				res |= 64'd1 << (29 - i);
			end
		end
		return res;
	endfunction

	function automatic logic [15:0] deviate(bit neg, logic [63:0] vsq,
			logic [63:0] s, logic [63:0] lv);
		int h;
		logic [63:0] r, q, mag;
		h = 0;
		while ((s >> h) >= (64'd1 << 32)) h++;
		r = ((vsq >> h) << 32) / (s >> h);
		q = r * lv;
		mag = isqrt(q >> (56 - 2 * FB));
		if (neg) begin
			if (mag > 32768) mag = 32768;
			return 16'((65536 - mag) & 16'hFFFF);
		end
		if (mag > 32767) mag = 32767;
		return mag[15:0];
	endfunction

	// pushes 0 or 2 expected words for one pair
	task automatic predict_pair(logic [UB-1:0] ua, logic [UB-1:0] ub);
		longint v1, v2;
		logic [63:0] sq1, sq2, s, x, g, lv;
		int n;
		v1 = longint'(ua) - (64'd1 << (UB - 1));
		v2 = longint'(ub) - (64'd1 << (UB - 1));
		sq1 = (v1 < 0 ? -v1 : v1) * (v1 < 0 ? -v1 : v1);
		sq2 = (v2 < 0 ? -v2 : v2) * (v2 < 0 ? -v2 : v2);
		s = sq1 + sq2;
		if (s == 0 || s >= (64'd1 << (2 * (UB - 1)))) return;
		n = 0;
		while ((s >> n) > 1) n++;
		x = (n >= 30) ? (s >> (n - 30)) : (s << (30 - n));
		g = (64'(2 * (UB - 1) - n) << 30) - log2_mant(x);
		lv = (g * 64'(TWO_LN2_Q26)) >> 32;
		pending_samples.insert(pending_samples.size(), {deviate(v1 < 0, sq1, s, lv), 1'b0});
		pending_samples.insert(pending_samples.size(), {deviate(v2 < 0, sq2, s, lv), 1'b1});
	endtask

	// ---- output checker and receiver stalls ----
	always @(posedge clk) begin
		sample_word_t e;
		if (arst_n) begin
			if (sample_valid && !sample_stall) begin
				n_words++;
				if (pending_samples.size() == 0) begin
					$error("unexpected word: sample=%0d last=%0b", sample, last);
					errors++;
				end else begin
					e = pending_samples.pop_front();
					if (sample !== e.smp) begin
						$error("sample: expected %0d, got %0d", $signed(e.smp), sample);
						errors++;
					end
					if (last !== e.lst) begin
						$error("last: expected %0b, got %0b", e.lst, last);
						errors++;
					end
				end
			end
			sample_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((uniform_valid && !uniform_stall) || (sample_valid && !sample_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Verification failed");
			$finish;
		end
	end

	// holds valid until the pair is taken; deasserts only on a random gap
	task automatic send_pair(logic [UB-1:0] ua, logic [UB-1:0] ub);
		while ($urandom_range(99) < send_idle_pct) begin
			uniform_valid <= 1'b0;
			@(posedge clk);
		end
		uniform_valid <= 1'b1;
		uniform_a <= ua;
		uniform_b <= ub;
		@(posedge clk);
		while (uniform_stall) @(posedge clk);
		predict_pair(ua, ub);
		n_pairs++;
	endtask

	task automatic drain();
		uniform_valid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	// well-formed bias: most random pairs land inside the unit circle
	task automatic random_pair();
		logic [UB-1:0] ua, ub;
		int r;
		r = $urandom_range(99);
		ua = UB'($urandom);
		ub = UB'($urandom);
		if (r < 70) begin
			ua = 16'(32768 + $signed($urandom_range(46340)) - 23170);
			ub = 16'(32768 + $signed($urandom_range(46340)) - 23170);
		end else if (r < 78) begin
			ua = 16'(32768 + $urandom_range(8) - 4);
			ub = 16'(32768 + $urandom_range(8) - 4);
		end
		send_pair(ua, ub);
	endtask

	pair_row_t dir_rows[$];

	initial begin
		pair_row_t row;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: rejects typed in, the rest go through the predictor
		dir_rows = '{
			'{16'h8000, 16'h8000, 1, 0, 0, 0},  // s is zero
			'{16'h0000, 16'h8000, 1, 0, 0, 0},  // v1 = -1, s = 1
			'{16'h0000, 16'h0000, 1, 0, 0, 0},  // corner, s = 2
			'{16'hFFFF, 16'hFFFF, 1, 0, 0, 0},  // corner positive
			'{16'hFFFF, 16'h8000, 0, 0, 0, 0},  // s just below one
			'{16'h0001, 16'h8000, 0, 0, 0, 0},  // v1 just above -1
			'{16'h8001, 16'h8000, 0, 0, 0, 0},  // tiny s
			'{16'h7FFF, 16'h8000, 0, 0, 0, 0},  // tiny negative
			'{16'h8000, 16'h8001, 0, 0, 0, 0},  // zero coordinate first
			'{16'h8001, 16'h8001, 0, 0, 0, 0},
			'{16'hC000, 16'hC000, 0, 0, 0, 0},
			'{16'h4000, 16'hC000, 0, 0, 0, 0},
			'{16'h4000, 16'h4000, 0, 0, 0, 0},
			'{16'hA000, 16'h6000, 0, 0, 0, 0},
			'{16'h8100, 16'h7F00, 0, 0, 0, 0},
			'{16'hD555, 16'h2AAA, 0, 0, 0, 0},
			'{16'h5A82, 16'h5A82, 0, 0, 0, 0}
		};
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.has_exp) begin
				// typed expectation replaces the predictor for this row
				send_pair_nopred(row.a, row.b);
				if (row.n_exp == 2) begin
					pending_samples.insert(pending_samples.size(), {row.s0, 1'b0});
					pending_samples.insert(pending_samples.size(), {row.s1, 1'b1});
				end
			end else begin
				send_pair(row.a, row.b);
			end
		end
		// sender holds off until everything is out
		drain();

		for (int i = 0; i < 340; i++) random_pair();
		drain();
		send_idle_pct = 69;
		recv_idle_pct = 32;
		for (int i = 0; i < 330; i++) random_pair();
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 330; i++) random_pair();
		drain();

		$display("Covered %0d uniform pairs and %0d sample words under three stall mixes.",
			n_pairs, n_words);
		if (errors == 0 && pending_samples.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	task automatic send_pair_nopred(logic [UB-1:0] ua, logic [UB-1:0] ub);
		uniform_valid <= 1'b1;
		uniform_a <= ua;
		uniform_b <= ub;
		@(posedge clk);
		while (uniform_stall) @(posedge clk);
		n_pairs++;
	endtask
endmodule
